### design/fdc_pkg.sv
// Shared constants and types for the factorial divisor count unit.
// No dependencies.
package fdc_pkg;
	localparam int unsigned DefMaxN = 65536;
	localparam int unsigned NWidth = 16;
	localparam int unsigned ResWidth = 30;
	localparam logic [29:0] Modulus = 30'd1000000007;

	typedef struct packed {
		logic sieve_start;
		logic query_start;
	} fdc_cmd_t;

	typedef struct packed {
		logic sieve_done;
		logic query_done;
	} fdc_status_t;
endpackage

### design/fdc_if.sv
// Valid/ready channel carrying one payload.
// No dependencies.
interface fdc_if #(parameter int unsigned W = 16) (input logic clk);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/fdc_datapath.sv
// Sieve bitmap, Legendre divider and modular multiplier.
// Depends on fdc_pkg.
module fdc_datapath #(
	parameter int unsigned MAX_N = fdc_pkg::DefMaxN
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fdc_pkg::fdc_cmd_t             cmd,
	input  logic [fdc_pkg::NWidth-1:0]    n,
	output fdc_pkg::fdc_status_t          status,
	output logic [fdc_pkg::ResWidth-1:0]  result
);
	import fdc_pkg::*;

	localparam int unsigned AW = $clog2(MAX_N + 1);
	localparam int unsigned DW = AW + 1;
	localparam int unsigned BW = $clog2(DW);

	typedef enum logic [3:0] {
		D_IDLE, S_INIT, S_OUTER, S_RD, S_CHK, S_MARK,
		Q_NEXT, Q_RD, Q_CHK, Q_DIV, Q_MUL, Q_RED
	} dstate_t;

	dstate_t state_q;
	logic mem [0:MAX_N];
	logic rd_q;
	logic [AW-1:0] addr_q, i_q, j_q, nq_q;
	logic [DW-1:0] x_q, quo_q, e_q;
	logic [BW-1:0] bit_q;
	logic [DW-1:0] rem_q;
	logic [59:0] prod_q;
	logic [ResWidth-1:0] acc_q;
	logic [5:0] red_q;
	logic sdone_q, qdone_q;
	logic [DW-1:0] rtry;
	logic qbit;
	logic [DW-1:0] qnext;
	logic [2*AW+1:0] sq;

	assign status = '{sieve_done: sdone_q, query_done: qdone_q};
	assign result = acc_q;
	assign rtry = {rem_q[DW-2:0], x_q[bit_q]};
	assign qbit = (rtry >= DW'(i_q));
	assign qnext = {quo_q[DW-2:0], qbit};
	assign sq = (2*AW+2)'(i_q) * (2*AW+2)'(i_q);

	always_ff @(posedge clk) begin
		rd_q <= mem[addr_q];
		if (state_q == S_INIT) mem[addr_q] <= (addr_q >= AW'(2));
		else if (state_q == S_MARK) mem[j_q] <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE; sdone_q <= 1'b0; qdone_q <= 1'b0;
			addr_q <= '0; i_q <= '0; j_q <= '0;
		end else begin
			qdone_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (cmd.sieve_start) begin
						addr_q <= '0; state_q <= S_INIT;
					end else if (cmd.query_start) begin
						nq_q <= ({16'd0, n} > 32'(MAX_N)) ? AW'(MAX_N) : AW'(n);
						i_q <= AW'(1); acc_q <= ResWidth'(1); state_q <= Q_NEXT;
					end
				end
				S_INIT: begin
					if (32'(addr_q) == MAX_N) begin
						i_q <= AW'(2); state_q <= S_OUTER;
					end else addr_q <= addr_q + AW'(1);
				end
				S_OUTER: begin
					if (64'(sq) > 64'(MAX_N)) begin
						sdone_q <= 1'b1; state_q <= D_IDLE;
					end else begin
						addr_q <= i_q; state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (rd_q) begin
						j_q <= AW'(sq); state_q <= S_MARK;
					end else begin
						i_q <= i_q + AW'(1); state_q <= S_OUTER;
					end
				end
				S_MARK: begin
					if (32'(j_q) + 32'(i_q) > MAX_N) begin
						i_q <= i_q + AW'(1); state_q <= S_OUTER;
					end else j_q <= j_q + i_q;
				end
				Q_NEXT: begin
					if (i_q >= nq_q) begin
						qdone_q <= 1'b1; state_q <= D_IDLE;
					end else begin
						i_q <= i_q + AW'(1); addr_q <= i_q + AW'(1); state_q <= Q_RD;
					end
				end
				Q_RD: state_q <= Q_CHK;
				Q_CHK: begin
					if (rd_q) begin
						x_q <= DW'(nq_q); e_q <= '0; rem_q <= '0; quo_q <= '0;
						bit_q <= BW'(AW - 1); state_q <= Q_DIV;
					end else state_q <= Q_NEXT;
				end
				Q_DIV: begin
					// restoring division of x by p, one bit per cycle
					if (bit_q == '0) begin
						x_q <= qnext;
						e_q <= e_q + qnext;
						rem_q <= '0; quo_q <= '0; bit_q <= BW'(AW - 1);
						if (qnext == '0) state_q <= Q_MUL;
					end else begin
						rem_q <= qbit ? rtry - DW'(i_q) : rtry;
						quo_q <= qnext;
						bit_q <= bit_q - BW'(1);
					end
				end
				Q_MUL: begin
					prod_q <= 60'(acc_q) * 60'(e_q + DW'(1));
					red_q <= 6'd29; state_q <= Q_RED;
				end
				Q_RED: begin
					// shift-subtract reduction of the product
					if (prod_q >= (60'(Modulus) << red_q))
						prod_q <= prod_q - (60'(Modulus) << red_q);
					if (red_q == '0) state_q <= Q_NEXT;
					else red_q <= red_q - 6'd1;
				end
				default: state_q <= D_IDLE;
			endcase
			if (state_q == Q_RED && red_q == '0)
				acc_q <= (prod_q >= 60'(Modulus)) ? ResWidth'(prod_q - 60'(Modulus))
					: ResWidth'(prod_q);
		end
	end
endmodule

### design/fdc_ctrl.sv
// Request sequencer: sieve after reset, then one query at a time.
// Depends on fdc_pkg.
module fdc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output fdc_pkg::fdc_cmd_t    cmd,
	input  fdc_pkg::fdc_status_t status
);
	import fdc_pkg::*;

	typedef enum logic [2:0] {C_START, C_SIEVE, C_IDLE, C_BUSY, C_OUT} cstate_t;
	cstate_t state_q;

	assign in_ready = (state_q == C_IDLE);
	assign out_valid = (state_q == C_OUT);
	assign cmd = '{sieve_start: state_q == C_START,
		query_start: (state_q == C_IDLE) && in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_START;
		end else begin
			unique case (state_q)
				C_START: state_q <= C_SIEVE;
				C_SIEVE: if (status.sieve_done) state_q <= C_IDLE;
				C_IDLE: if (in_valid) state_q <= C_BUSY;
				C_BUSY: if (status.query_done) state_q <= C_OUT;
				C_OUT: if (out_ready) state_q <= C_IDLE;
				default: state_q <= C_START;
			endcase
		end
	end
endmodule

### design/factorial_divisor_count_mod_unit.sv
// Number of divisors of n!, modulo 1000000007, one request at a time.
// After reset a sieve pass fills the prime bitmap; no request is taken until it ends.
// A request then walks every integer up to n and, per prime p, runs a bit-serial Legendre
// division for each term of the sum and a shift-subtract modular multiply.
// Depends on fdc_pkg, fdc_if.
module factorial_divisor_count_mod_unit #(
	parameter int unsigned MAX_N = fdc_pkg::DefMaxN
) (
	input logic clk,
	input logic arst_n,
	fdc_if.sink   in_ch,
	fdc_if.source out_ch
);
	import fdc_pkg::*;

	fdc_cmd_t    cmd;
	fdc_status_t status;

	fdc_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd, .status
	);

	fdc_datapath #(.MAX_N(MAX_N)) u_dp (
		.clk, .arst_n, .cmd, .n(in_ch.data[NWidth-1:0]), .status,
		.result(out_ch.data[ResWidth-1:0])
	);
endmodule

### tb/factorial_divisor_count_mod_unit_tb.sv
// Testbench for factorial_divisor_count_mod_unit: directed and random values of n,
// with answers predicted from a local sieve and Legendre sums.
// Depends on fdc_pkg, fdc_if and the unit itself.
class divisor_scoreboard;
	bit          is_prime [0:fdc_pkg::DefMaxN];
	logic [29:0] expected_counts [$];
	int unsigned mismatches;
	int unsigned results_seen;

	function new();
		int unsigned i;
		int unsigned j;
		for (i = 0; i <= fdc_pkg::DefMaxN; i++) is_prime[i] = (i >= 2);
		for (i = 2; i * i <= fdc_pkg::DefMaxN; i++) begin
			if (is_prime[i]) begin
				for (j = i * i; j <= fdc_pkg::DefMaxN; j += i) is_prime[j] = 0;
			end
		end
		mismatches = 0;
		results_seen = 0;
	endfunction

	function logic [29:0] divisor_count_of_factorial(logic [15:0] n);
		longint unsigned prod;
		int unsigned     p;
		int unsigned     x;
		int unsigned     e;
		prod = 1;
		for (p = 2; p <= n; p++) begin
			if (is_prime[p]) begin
				x = n;
				e = 0;
				while (x != 0) begin
					x = x / p;
					e += x;
				end
				prod = (prod * (e + 1)) % longint'(fdc_pkg::Modulus);
			end
		end
		return prod[29:0];
	endfunction

	function void note_request(logic [15:0] n);
		expected_counts = {expected_counts, divisor_count_of_factorial(n)};
	endfunction

	function void check_result(logic [29:0] actual);
		logic [29:0] want;
		results_seen++;
		if (expected_counts.size() == 0) begin
			$display("%0t: unexpected result %0d", $time, actual);
			mismatches++;
			return;
		end
		want = expected_counts.pop_front();
		if (actual !== want) begin
			$display("%0t: divisor_count expected %0d, got %0d", $time, want, actual);
			mismatches++;
		end
	endfunction
endclass

module factorial_divisor_count_mod_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	fdc_if #(.W(16)) in_ch (clk);
	fdc_if #(.W(30)) out_ch (clk);

	divisor_scoreboard sb;
	bit                hold_off_req;
	bit                no_idle;
	int unsigned       max_n_sent;

	factorial_divisor_count_mod_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.data);
		if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
	end

	task automatic send_request(logic [15:0] n);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		repeat (gap) begin
			@(negedge clk);
			in_ch.valid <= 0;
		end
		@(negedge clk);
		in_ch.valid <= 1;
		in_ch.data <= n;
		do @(posedge clk); while (!in_ch.ready);
		if (n > max_n_sent) max_n_sent = n;
		@(negedge clk);
		in_ch.valid <= 0;
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin
		int unsigned gap;
		out_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 0;
				@(negedge clk);
				out_ch.ready <= 0;
				repeat (3000) @(negedge clk);
			end
			gap = no_idle ? 0 : $urandom_range(0, 6);
			repeat (gap) begin
				@(negedge clk);
				out_ch.ready <= 0;
			end
			@(negedge clk);
			out_ch.ready <= 1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	initial begin
		logic [15:0] directed [$];
		logic [15:0] n;
		sb = new();
		hold_off_req = 0;
		no_idle = 0;
		max_n_sent = 0;
		in_ch.valid = 0;
		in_ch.data = '0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd10,
			16'd16, 16'd31, 16'd32, 16'd97, 16'd100, 16'd127, 16'd128, 16'd255,
			16'd256, 16'd1000, 16'd1024, 16'd4096, 16'd65535};
		foreach (directed[i]) send_request(directed[i]);

		for (int k = 0; k < 80; k++) begin
			if (k == 20) hold_off_req = 1;
			no_idle = (k >= 50 && k < 65);
			if ($urandom_range(0, 19) == 0) n = 16'($urandom_range(0, 4000));
			else n = 16'($urandom_range(0, 600));
			send_request(n);
		end

		while (sb.expected_counts.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("covered %0d requests, n from 0 up to %0d, with random stalls",
			sb.results_seen, max_n_sent);
		$display("and a 3000-cycle result-side hold-off that backed up the input");
		if (sb.mismatches == 0 && sb.expected_counts.size() == 0) begin
			$display("factorial_divisor_count_mod_unit_tb: done, clean");
		end else begin
			$display("factorial_divisor_count_mod_unit_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#300ms;
		$display("timeout at %0t", $time);
		$display("factorial_divisor_count_mod_unit_tb: done, errors");
		$finish;
	end
endmodule
